### sv/binary_image_quadtree_encoder_top_macros.svh
// Assertion macros for the quadtree encoder checker.
// No dependencies; included by the checker module.
`ifndef BINARY_IMAGE_QUADTREE_ENCODER_TOP_MACROS_SVH
`define BINARY_IMAGE_QUADTREE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define QTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define QTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/qte_pkg.sv
// Shared codes and types for the quadtree encoder.
// No dependencies; imported by every module of the block but qte_pixmem.
package qte_pkg;

    // Input operation codes (s_tuser)
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_FETCH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Code symbols
    localparam logic [1:0] SYM_WHITE = 2'd0;
    localparam logic [1:0] SYM_BLACK = 2'd1;
    localparam logic [1:0] SYM_SPLIT = 2'd2;

    // Configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Result of one region scan
    typedef struct packed {
        logic       done;
        logic [1:0] symbol;
    } scan_rsp_t;

endpackage

### sv/qte_pixmem.sv
// Pixel store: one write port, one read port with registered data.
// No dependencies; used by the quadtree encoder top level.
module qte_pixmem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/qte_scan.sv
// Region scanner: walks a rectangle one pixel a cycle and judges uniformity.
// Depends on qte_pkg; reads the pixel store through its read port.
module qte_scan
    import qte_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int RW       = 7,
    parameter int CW       = 7,
    parameter int AW       = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [RW-1:0] r0,
    input  logic [RW-1:0] r1,
    input  logic [CW-1:0] c0,
    input  logic [CW-1:0] c1,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic          rd_data,
    output scan_rsp_t     rsp
);

    logic          busy_reg;
    logic          active_reg;
    logic          inflight_reg;
    logic          inflight_last_reg;
    logic          have_first_reg;
    logic          color_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    scan_rsp_t     rsp_reg;

    logic          row_end;
    logic          cell_last;

    assign row_end   = (CW'(c_reg + 1'b1) == c1);
    assign cell_last = row_end && (RW'(r_reg + 1'b1) == r1);
    assign rd_en     = active_reg;
    assign rd_addr   = AW'(int'(r_reg) * MAX_COLS + int'(c_reg));
    assign rsp       = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            active_reg   <= 1'b0;
            inflight_reg <= 1'b0;
            rsp_reg.done <= 1'b0;
        end else begin
            rsp_reg.done <= 1'b0;
            if (start) begin
                busy_reg       <= 1'b1;
                active_reg     <= 1'b1;
                inflight_reg   <= 1'b0;
                have_first_reg <= 1'b0;
                r_reg          <= r0;
                c_reg          <= c0;
            end else if (busy_reg) begin
                // advance the read address in raster order
                if (active_reg) begin
                    if (cell_last) begin
                        active_reg <= 1'b0;
                    end else if (row_end) begin
                        c_reg <= c0;
                        r_reg <= RW'(r_reg + 1'b1);
                    end else begin
                        c_reg <= CW'(c_reg + 1'b1);
                    end
                end
                inflight_reg      <= active_reg;
                inflight_last_reg <= active_reg && cell_last;
                // judge the pixel that returns this cycle
                if (inflight_reg) begin
                    if (!have_first_reg) begin
                        color_reg      <= rd_data;
                        have_first_reg <= 1'b1;
                        if (inflight_last_reg) begin
                            rsp_reg.done   <= 1'b1;
                            rsp_reg.symbol <= rd_data ? SYM_BLACK : SYM_WHITE;
                            busy_reg       <= 1'b0;
                        end
                    end else if (rd_data != color_reg) begin
                        // mixed: drop the rest of the walk
                        rsp_reg.done   <= 1'b1;
                        rsp_reg.symbol <= SYM_SPLIT;
                        busy_reg       <= 1'b0;
                        active_reg     <= 1'b0;
                        inflight_reg   <= 1'b0;
                    end else if (inflight_last_reg) begin
                        rsp_reg.done   <= 1'b1;
                        rsp_reg.symbol <= color_reg ? SYM_BLACK : SYM_WHITE;
                        busy_reg       <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

### sv/qte_ctrl.sv
// Sequencer: input decode, region stack, settling of the stack top, output word.
// Depends on qte_pkg; drives the pixel store write port and the region scanner.
module qte_ctrl
    import qte_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int RW       = 7,
    parameter int CW       = 7,
    parameter int AW       = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [6:0]    cfg_rows,
    input  logic [6:0]    cfg_cols,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic          wr_data,
    output logic          scan_start,
    output logic [RW-1:0] g_r0,
    output logic [RW-1:0] g_r1,
    output logic [CW-1:0] g_c0,
    output logic [CW-1:0] g_c1,
    input  scan_rsp_t     scan_rsp
);

    localparam int MAXDIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DEPTH  = $clog2(MAXDIM) + 1;
    localparam int SPW    = $clog2(DEPTH + 1);
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [RW-1:0] r0;
        logic [RW-1:0] r1;
        logic [CW-1:0] c0;
        logic [CW-1:0] c1;
        logic [2:0]    quad;
    } entry_t;

    typedef enum logic [1:0] {C_IDLE, C_SCAN, C_SETTLE, C_OUT} state_t;

    state_t         state_reg;
    entry_t         stk_reg [DEPTH];
    logic [SPW-1:0] sp_reg;
    logic           started_reg;
    entry_t         g_reg;
    logic [1:0]     sym_reg;
    logic           scan_start_reg;
    logic           m_valid_reg;
    logic [1:0]     m_sym_reg;
    logic           m_last_reg;

    logic           accept;
    logic [5:0]     px_row;
    logic [5:0]     px_col;
    logic [SPW-1:0] sp_dec;
    logic [IW-1:0]  top_idx;
    entry_t         top;
    entry_t         top_q;
    logic           top_empty;
    entry_t         root;

    function automatic entry_t quad_of(entry_t p, logic [1:0] q);
        logic [RW:0]   rspan;
        logic [CW:0]   cspan;
        logic [RW-1:0] mr;
        logic [CW-1:0] mc;
        entry_t        s;
        rspan  = {1'b0, p.r1} - {1'b0, p.r0} + 1'b1;
        cspan  = {1'b0, p.c1} - {1'b0, p.c0} + 1'b1;
        mr     = p.r0 + rspan[RW:1];
        mc     = p.c0 + cspan[CW:1];
        s.r0   = q[1] ? mr   : p.r0;
        s.r1   = q[1] ? p.r1 : mr;
        s.c0   = q[0] ? mc   : p.c0;
        s.c1   = q[0] ? p.c1 : mc;
        s.quad = 3'd0;
        return s;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == C_IDLE);
    assign px_row   = s_tdata[5:0];
    assign px_col   = s_tdata[11:6];

    assign wr_en   = accept && (s_tuser == OP_WRITE)
                     && (int'(px_row) < MAX_ROWS) && (int'(px_col) < MAX_COLS);
    assign wr_addr = AW'(int'(px_row) * MAX_COLS + int'(px_col));
    assign wr_data = s_tdata[12];

    assign sp_dec    = sp_reg - 1'b1;
    assign top_idx   = sp_dec[IW-1:0];
    assign top       = stk_reg[top_idx];
    assign top_q     = quad_of(top, top.quad[1:0]);
    assign top_empty = (top_q.r0 >= top_q.r1) || (top_q.c0 >= top_q.c1);

    always_comb begin
        root.r0   = '0;
        root.c0   = '0;
        root.quad = 3'd0;
        if (cfg_rows == '0) begin
            root.r1 = RW'(1);
        end else if (int'(cfg_rows) > MAX_ROWS) begin
            root.r1 = RW'(MAX_ROWS);
        end else begin
            root.r1 = RW'(cfg_rows);
        end
        if (cfg_cols == '0) begin
            root.c1 = CW'(1);
        end else if (int'(cfg_cols) > MAX_COLS) begin
            root.c1 = CW'(MAX_COLS);
        end else begin
            root.c1 = CW'(cfg_cols);
        end
    end

    assign scan_start = scan_start_reg;
    assign g_r0       = g_reg.r0;
    assign g_r1       = g_reg.r1;
    assign g_c0       = g_reg.c0;
    assign g_c1       = g_reg.c1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {6'd0, m_sym_reg};
    assign m_tlast    = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= C_IDLE;
            sp_reg         <= '0;
            started_reg    <= 1'b0;
            scan_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            scan_start_reg <= 1'b0;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                C_IDLE: begin
                    if (accept) begin
                        unique case (s_tuser)
                            OP_RESTART: begin
                                started_reg <= 1'b0;
                                sp_reg      <= '0;
                            end
                            OP_FETCH: begin
                                if (!started_reg) begin
                                    g_reg          <= root;
                                    started_reg    <= 1'b1;
                                    scan_start_reg <= 1'b1;
                                    state_reg      <= C_SCAN;
                                end else if (sp_reg != '0) begin
                                    g_reg                <= top_q;
                                    stk_reg[top_idx].quad <= top.quad + 3'd1;
                                    scan_start_reg       <= 1'b1;
                                    state_reg            <= C_SCAN;
                                end
                            end
                            default: begin
                                // writes go straight to the store; unused op is dropped
                            end
                        endcase
                    end
                end
                C_SCAN: begin
                    if (scan_rsp.done) begin
                        sym_reg <= scan_rsp.symbol;
                        if ((scan_rsp.symbol == SYM_SPLIT) && (sp_reg < SPW'(DEPTH))) begin
                            stk_reg[sp_reg[IW-1:0]] <= g_reg;
                            sp_reg                  <= sp_reg + 1'b1;
                        end
                        state_reg <= C_SETTLE;
                    end
                end
                C_SETTLE: begin
                    // one step a cycle: pop spent entries, skip empty quadrants
                    if (sp_reg == '0) begin
                        state_reg <= C_OUT;
                    end else if (top.quad[2]) begin
                        sp_reg <= sp_dec;
                    end else if (top_empty) begin
                        stk_reg[top_idx].quad <= top.quad + 3'd1;
                    end else begin
                        state_reg <= C_OUT;
                    end
                end
                C_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_sym_reg   <= sym_reg;
                        m_last_reg  <= (sp_reg == '0);
                        state_reg   <= C_IDLE;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/binary_image_quadtree_encoder_top.sv
// Top level of the binary image region quadtree encoder.
// Depends on qte_pkg, qte_pixmem, qte_scan and qte_ctrl.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid/s_tready    tuser op, tdata row/col/value
//   m_       out        m_tvalid/m_tready    tdata symbol, tlast end of code
//   cfg_     in         cfg_wr_en (no wait)  cfg_addr index, cfg_wr_data value
//
// A write, restart or dropped word leaves the block ready for the next word.
// A fetch scans its region, the scanner reading the pixel store one pixel a
// cycle, and then settles the stack a step at a time (pop or skipped quadrant).
// Reset is synchronous and active low; the pixel store is not cleared.
// s_tready is low while a fetch is in progress; a finished symbol waits in
// the output register, and a new word is taken while it waits.
module binary_image_quadtree_encoder_top
    import qte_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wr_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] pixel_row, [11:6] pixel_col, [12] pixel_value
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] symbol
    output logic        m_tlast    // last_symbol
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);

    // Window size registers; latched into the root region on the first fetch
    logic [6:0] rows_reg;
    logic [6:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd64;
            cols_reg <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ROWS: rows_reg <= cfg_wr_data;
                REG_COLS: cols_reg <= cfg_wr_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // Pixel store ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_data;

    // Sequencer to scanner
    logic          scan_start;
    logic [RW-1:0] g_r0;
    logic [RW-1:0] g_r1;
    logic [CW-1:0] g_c0;
    logic [CW-1:0] g_c1;
    scan_rsp_t     scan_rsp;

    qte_pixmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pixmem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Single scan unit: judges the region of each fetch; a fetch after the code end starts none
    qte_scan #(
        .MAX_COLS (MAX_COLS),
        .RW       (RW),
        .CW       (CW),
        .AW       (AW)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .r0      (g_r0),
        .r1      (g_r1),
        .c0      (g_c0),
        .c1      (g_c1),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (scan_rsp)
    );

    // Sequencer: decode words, walk the region stack, hold the result word
    qte_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RW       (RW),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_rows   (rows_reg),
        .cfg_cols   (cols_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .scan_start (scan_start),
        .g_r0       (g_r0),
        .g_r1       (g_r1),
        .g_c0       (g_c0),
        .g_c1       (g_c1),
        .scan_rsp   (scan_rsp)
    );

endmodule

### sv/qte_checker.sv
// Port-level checker for the quadtree encoder, bound to the top level.
// Depends on qte_pkg and binary_image_quadtree_encoder_top_macros.svh.
`include "binary_image_quadtree_encoder_top_macros.svh"

module qte_checker
    import qte_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled result word holds
    `QTE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

    // only legal symbols and zero padding leave the block
    `QTE_ASSERT_NOW(a_out_legal, m_tvalid, (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] == SYM_WHITE || m_tdata[1:0] == SYM_BLACK || m_tdata[1:0] == SYM_SPLIT), "illegal result symbol")

    // a word that is not a fetch never blocks the next one
    `QTE_ASSERT_NEXT(a_nonfetch_ready, s_tvalid && s_tready && (s_tuser != OP_FETCH), s_tready, "ready dropped after a non-fetch word")

    // a new result appears only at the end of a fetch, while input is held off
    `QTE_ASSERT_NOW(a_out_from_fetch, $rose(m_tvalid), !$past(s_tready), "result appeared without a fetch in progress")

endmodule

bind binary_image_quadtree_encoder_top qte_checker u_qte_checker (.*);

### sim/qte_tb_pkg.sv
// Testbench support for the quadtree encoder: region types and a code tracker class.
// Depends on qte_pkg for op, symbol and register codes; used by tb_top.
package qte_tb_pkg;
    import qte_pkg::*;

    localparam int IMG_DIM          = 64;
    localparam int CODE_STACK_DEPTH = 11;
    localparam int MAX_REPORTS      = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // r1 and c1 are exclusive ends; quad is the next quadrant to visit
    typedef struct {
        int r0;
        int r1;
        int c0;
        int c1;
        int quad;
    } quad_region_t;

    typedef struct {
        logic [1:0] symbol;
        logic       last;
    } code_sym_t;

    // 0 counts as 1, anything past the image edge counts as the edge
    function automatic int clamp_extent(logic [6:0] v);
        if (v == 0) return 1;
        if (v > IMG_DIM) return IMG_DIM;
        return int'(v);
    endfunction

    class qtree_code_tracker;
        bit           pixels[IMG_DIM][IMG_DIM];
        bit           written[IMG_DIM][IMG_DIM];
        quad_region_t open_regions[CODE_STACK_DEPTH];
        int           depth;
        bit           started;
        logic [6:0]   rows_reg;
        logic [6:0]   cols_reg;
        code_sym_t    pending_symbols[$];
        int           mismatches;
        int           symbols_checked;

        function new();
            rows_reg        = 7'd64;
            cols_reg        = 7'd64;
            depth           = 0;
            started         = 0;
            mismatches      = 0;
            symbols_checked = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] val);
            if (idx == REG_ROWS) rows_reg = val;
            else cols_reg = val;
        endfunction

        function quad_region_t quadrant(quad_region_t p, int q);
            quad_region_t s;
            int mr;
            int mc;
            mr = p.r0 + (p.r1 - p.r0 + 1) / 2;
            mc = p.c0 + (p.c1 - p.c0 + 1) / 2;
            s.r0   = (q & 2) ? mr : p.r0;
            s.r1   = (q & 2) ? p.r1 : mr;
            s.c0   = (q & 1) ? mc : p.c0;
            s.c1   = (q & 1) ? p.c1 : mc;
            s.quad = 0;
            return s;
        endfunction

        function logic [1:0] classify(quad_region_t g);
            bit first;
            first = pixels[g.r0][g.c0];
            for (int r = g.r0; r < g.r1; r++)
                for (int c = g.c0; c < g.c1; c++)
                    if (pixels[r][c] != first) return SYM_SPLIT;
            return first ? SYM_BLACK : SYM_WHITE;
        endfunction

        // Pop spent regions and skip empty quadrants of odd-sized ones
        function void settle();
            quad_region_t q;
            while (depth > 0) begin
                if (open_regions[depth-1].quad >= 4) begin
                    depth--;
                    continue;
                end
                q = quadrant(open_regions[depth-1], open_regions[depth-1].quad);
                if (q.r0 >= q.r1 || q.c0 >= q.c1) begin
                    open_regions[depth-1].quad++;
                    continue;
                end
                break;
            end
        endfunction

        function void next_symbol();
            quad_region_t g;
            code_sym_t    s;
            if (!started) begin
                g = '{0, clamp_extent(rows_reg), 0, clamp_extent(cols_reg), 0};
                started = 1;
            end else if (depth == 0) begin
                return;
            end else begin
                g = quadrant(open_regions[depth-1], open_regions[depth-1].quad);
                open_regions[depth-1].quad++;
            end
            s.symbol = classify(g);
            if (s.symbol == SYM_SPLIT && depth < CODE_STACK_DEPTH) begin
                open_regions[depth] = g;
                depth++;
            end
            settle();
            s.last = (depth == 0);
            pending_symbols.push_back(s);
        endfunction

        function void note_word(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                logic value);
            case (op)
                OP_WRITE: begin
                    pixels[row][col]  = value;
                    written[row][col] = 1;
                end
                OP_RESTART: begin
                    started = 0;
                    depth   = 0;
                end
                OP_FETCH: next_symbol();
                default: ;
            endcase
        endfunction

        function void check_symbol(logic [1:0] symbol, logic last);
            code_sym_t want;
            symbols_checked++;
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected symbol %0d last %0b, none pending",
                             $realtime, symbol, last);
                return;
            end
            want = pending_symbols.pop_front();
            if (want.symbol !== symbol || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] symbol mismatch: expected %0d last %0b, got %0d last %0b",
                             $realtime, want.symbol, want.last, symbol, last);
            end
        endfunction

        function bit code_ended();
            return started && depth == 0;
        endfunction

        function int pending();
            return pending_symbols.size();
        endfunction
    endclass

endpackage

### sim/tb_top.sv
// Top-level testbench for binary_image_quadtree_encoder_top: drives words, checks symbols.
// Depends on qte_pkg and qte_tb_pkg (code tracker class); needs only the RTL otherwise.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qte_pkg::*;
    import qte_tb_pkg::*;

    // Run limit, well above the slowest legal run
    localparam int CYCLE_LIMIT      = 3_000_000;
    // Wait after draining: covers a full 64x64 scan plus its control and settling steps
    localparam int SETTLE_CYCLES    = 4200;
    localparam int LONG_HOLD_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [5:0] pixel_row, [11:6] pixel_col, [12] pixel_value
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [1:0] symbol
    logic        m_tlast;   // last_symbol

    qtree_code_tracker code_sb = new();

    int words_sent     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    bit steady         = 0;   // no idling on either side while set
    bit hold_off_req   = 0;   // ask the receiver for one long stall

    binary_image_quadtree_encoder_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run; a hung handshake ends here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d symbols still pending",
                     cycle_count, code_sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Check every accepted result word against the oldest pending symbol
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready)
            code_sb.check_symbol(m_tdata[1:0], m_tlast);
    end

    // Result receiver: draw a stall before each word, or one long hold-off on request
    initial begin
        int stall;
        m_tready = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (hold_off_req) begin
                hold_off_req = 0;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Offer one word after a random gap, hold it until taken, then note it.
    // Called and returns at a falling edge.
    task automatic send_word(input logic [1:0] op, input logic [5:0] row,
                             input logic [5:0] col, input logic value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, value, col, row};
        do @(posedge aclk); while (!s_tready);
        code_sb.note_word(op, row, col, value);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_fetch();
        send_word(OP_FETCH, 6'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // Write both window registers on consecutive cycles; no wait on the port
    task automatic write_window(input logic [6:0] rows_val, input logic [6:0] cols_val);
        cfg_wr_en   <= 1;
        cfg_addr    <= REG_ROWS;
        cfg_wr_data <= rows_val;
        @(negedge aclk);
        cfg_addr    <= REG_COLS;
        cfg_wr_data <= cols_val;
        @(negedge aclk);
        cfg_wr_en   <= 0;
        code_sb.set_reg(REG_ROWS, rows_val);
        code_sb.set_reg(REG_COLS, cols_val);
        settings_used++;
    endtask

    // Drop valid, wait for all pending symbols, then let a possible silent fetch finish
    task automatic drain();
        s_tvalid <= 0;
        while (code_sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Paint the window: background with noise_pm per mille of the other color.
    // Without repaint only pixels never written are touched, so no fetch reads garbage.
    task automatic paint_window(input bit bg, input int noise_pm, input bit repaint);
        int nr;
        int nc;
        nr = clamp_extent(code_sb.rows_reg);
        nc = clamp_extent(code_sb.cols_reg);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                if (repaint || !code_sb.written[r][c])
                    send_word(OP_WRITE, 6'(r), 6'(c),
                              ($urandom_range(0, 999) < noise_pm) ? !bg : bg);
    endtask

    task automatic finish_code();
        while (!code_sb.code_ended()) send_fetch();
    endtask

    // Mostly fetches that walk the code; some writes mid-code, rare restarts and
    // unused ops. Once the code has ended, mostly restart.
    task automatic random_words(input int budget);
        int pick;
        int nr;
        int nc;
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        for (int i = 0; i < budget; i++) begin
            nr   = clamp_extent(code_sb.rows_reg);
            nc   = clamp_extent(code_sb.cols_reg);
            row  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, nr - 1));
            col  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, nc - 1));
            pick = $urandom_range(0, 99);
            if (code_sb.code_ended()) begin
                if (pick < 55)      op = OP_RESTART;
                else if (pick < 75) op = OP_FETCH;
                else if (pick < 90) op = OP_WRITE;
                else                op = OP_UNUSED;
            end else begin
                if (pick < 80)      op = OP_FETCH;
                else if (pick < 92) op = OP_WRITE;
                else if (pick < 94) op = OP_RESTART;
                else                op = OP_UNUSED;
            end
            send_word(op, row, col, 1'($urandom_range(0, 1)));
        end
    endtask

    // One window setting: go idle, set the window, paint it, then run random words.
    // Leaving the code unfinished carries it into the next setting.
    task automatic run_phase(input logic [6:0] rows_val, input logic [6:0] cols_val,
                             input bit bg, input int noise_pm, input bit repaint,
                             input int budget, input bit finish, input bit pace);
        drain();
        write_window(rows_val, cols_val);
        steady = pace;
        paint_window(bg, noise_pm, repaint);
        random_words(budget);
        if (finish) finish_code();
    endtask

    initial begin
        aresetn     = 0;
        cfg_wr_en   = 0;
        cfg_addr    = REG_ROWS;
        cfg_wr_data = '0;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tuser     = OP_WRITE;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Single pixel window from zero-valued registers: black, then nothing past
        // the end, an unused op, then a restart on a white pixel.
        write_window(7'd0, 7'd0);
        send_word(OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_fetch();
        send_fetch();
        send_word(OP_UNUSED, 6'd63, 6'd63, 1'b1);
        send_word(OP_RESTART, 6'd0, 6'd0, 1'b0);
        send_word(OP_WRITE, 6'd0, 6'd0, 1'b0);
        send_fetch();

        // 3x3 window, one black pixel top right: odd splits skip empty quadrants.
        // Hit the far corners of the pixel fields between restart and fetches.
        drain();
        write_window(7'd3, 7'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                send_word(OP_WRITE, 6'(r), 6'(c), (r == 0 && c == 2));
        send_word(OP_RESTART, 6'd0, 6'd0, 1'b0);
        send_word(OP_WRITE, 6'd63, 6'd63, 1'b1);
        send_word(OP_WRITE, 6'd63, 6'd0, 1'b0);
        send_word(OP_WRITE, 6'd0, 6'd63, 1'b1);
        finish_code();

        // Odd 3x5 window with no idling at all; new pixels noisy, code left unfinished
        run_phase(7'd3, 7'd5, 1'b0, 500, 1'b0, 8, 1'b0, 1'b1);
        // Tall single column from an over-range row count: the old code finishes on
        // its latched window first, then a restart walks the full-height column
        run_phase(7'd127, 7'd1, 1'b0, 0, 1'b0, 4, 1'b1, 1'b0);
        send_word(OP_RESTART, 6'd0, 6'd0, 1'b0);
        finish_code();
        // Busy 3x4 window with one long receiver hold-off so the input side backs up
        hold_off_req = 1;
        run_phase(7'd3, 7'd4, 1'b1, 0, 1'b0, 10, 1'b1, 1'b0);
        drain();

        $display("Sent %0d words over %0d window settings, from one pixel to a full column.",
                 words_sent, settings_used);
        $display("Checked %0d code symbols, %0d mismatches, %0d left pending.",
                 code_sb.symbols_checked, code_sb.mismatches, code_sb.pending());
        if (code_sb.mismatches == 0 && code_sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
